### hw/rtl/vtir_pkg.sv
// Shared types and constants for the 6522-style timer and interrupt register block.
package vtir_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned IRQ_W  = 7;

  // Item kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  // Standard 6522 register map
  typedef enum logic [ADDR_W-1:0] {
    REG_ORB    = 4'd0,
    REG_ORA    = 4'd1,
    REG_DDRB   = 4'd2,
    REG_DDRA   = 4'd3,
    REG_T1CL   = 4'd4,
    REG_T1CH   = 4'd5,
    REG_T1LL   = 4'd6,
    REG_T1LH   = 4'd7,
    REG_T2CL   = 4'd8,
    REG_T2CH   = 4'd9,
    REG_SR     = 4'd10,
    REG_ACR    = 4'd11,
    REG_PCR    = 4'd12,
    REG_IFR    = 4'd13,
    REG_IER    = 4'd14,
    REG_ORA_NH = 4'd15
  } reg_addr_t;

  // Interrupt flag bit positions
  localparam int unsigned FLAG_T1_BIT = 6;
  localparam int unsigned FLAG_T2_BIT = 5;
  // ACR free-run bit for timer 1
  localparam int unsigned ACR_FREE_RUN_BIT = 6;

  localparam logic [CNT_W-1:0] T1_RESET = 16'hFFFF;

  // One accepted item
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] reg_offset;
    logic [DATA_W-1:0] write_data;
  } vtir_item_t;

  // Result of one item
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_request;
  } vtir_result_t;

  // Register file status for checking
  typedef struct packed {
    logic irq;
    logic t1_at_zero;
    logic t1_reload_pending;
  } vtir_status_t;

endpackage

### hw/rtl/vtir_if.sv
// Valid/ready channel interfaces for command items and result items.
interface vtir_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [vtir_pkg::FUNC_W-1:0]  func;
  logic [vtir_pkg::ADDR_W-1:0]  reg_offset;
  logic [vtir_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, func, reg_offset, write_data, input ready);
  modport sink (input valid, func, reg_offset, write_data, output ready);
endinterface

interface vtir_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [vtir_pkg::DATA_W-1:0]  read_data;
  logic                         irq_request;

  modport source (output valid, read_data, irq_request, input ready);
  modport sink (input valid, read_data, irq_request, output ready);
endinterface

### hw/rtl/vtir_in_stage.sv
// Input register stage: captures one command item and holds it until the core takes it.
module vtir_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  vtir_cmd_if.sink             cmd,
  input  logic                 advance,
  output logic                 stage_valid,
  output vtir_pkg::vtir_item_t item
);
  import vtir_pkg::*;

  // Slot frees up whenever the held item moves on
  assign cmd.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.func       <= cmd.func;
      item.reg_offset <= cmd.reg_offset;
      item.write_data <= cmd.write_data;
    end
  end

endmodule

### hw/rtl/vtir_regs.sv
// Register file, timers and interrupt logic; updates state once per executed item.
module vtir_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  vtir_pkg::vtir_item_t   item,
  output vtir_pkg::vtir_result_t result,
  output vtir_pkg::vtir_status_t status
);
  import vtir_pkg::*;

  logic [DATA_W-1:0] orb, ora, ddrb, ddra;
  logic [CNT_W-1:0]  t1c, t2c;
  logic [DATA_W-1:0] t1l_lo, t1l_hi, t2_latch_lo;
  logic [DATA_W-1:0] sr, acr, pcr;
  logic [IRQ_W-1:0]  ifr, ier;
  logic              t1_armed, t2_armed, t1_at_zero, t1_reload_pending;

  logic [DATA_W-1:0] orb_next, ora_next, ddrb_next, ddra_next;
  logic [CNT_W-1:0]  t1c_next, t2c_next;
  logic [DATA_W-1:0] t1l_lo_next, t1l_hi_next, t2_latch_lo_next;
  logic [DATA_W-1:0] sr_next, acr_next, pcr_next;
  logic [IRQ_W-1:0]  ifr_next, ier_next;
  logic              t1_armed_next, t2_armed_next, t1_at_zero_next, t1_reload_pending_next;

  logic [CNT_W-1:0]  t1_dec, t2_dec;
  logic [DATA_W-1:0] rd;
  logic              irq_now;

  assign t1_dec  = t1c - CNT_W'(1);
  assign t2_dec  = t2c - CNT_W'(1);
  assign irq_now = |(ifr & ier);

  // Next-state and read data for the item in the input register
  always_comb begin
    orb_next               = orb;
    ora_next               = ora;
    ddrb_next              = ddrb;
    ddra_next              = ddra;
    t1c_next               = t1c;
    t2c_next               = t2c;
    t1l_lo_next            = t1l_lo;
    t1l_hi_next            = t1l_hi;
    t2_latch_lo_next       = t2_latch_lo;
    sr_next                = sr;
    acr_next               = acr;
    pcr_next               = pcr;
    ifr_next               = ifr;
    ier_next               = ier;
    t1_armed_next          = t1_armed;
    t2_armed_next          = t2_armed;
    t1_at_zero_next        = t1_at_zero;
    t1_reload_pending_next = t1_reload_pending;
    rd                     = '0;

    unique case (func_t'(item.func))
      FUNC_READ: begin
        unique case (reg_addr_t'(item.reg_offset)) inside
          REG_ORB:             rd = orb;
          REG_ORA, REG_ORA_NH: rd = ora;
          REG_DDRB:            rd = ddrb;
          REG_DDRA:            rd = ddra;
          REG_T1CL: begin
            rd = t1c[DATA_W-1:0];
            ifr_next[FLAG_T1_BIT] = 1'b0;
          end
          REG_T1CH:            rd = t1c[CNT_W-1:DATA_W];
          REG_T1LL: begin
            rd = t1l_lo;
            ifr_next[FLAG_T1_BIT] = 1'b0;
          end
          REG_T1LH:            rd = t1l_hi;
          REG_T2CL: begin
            rd = t2c[DATA_W-1:0];
            ifr_next[FLAG_T2_BIT] = 1'b0;
          end
          REG_T2CH:            rd = t2c[CNT_W-1:DATA_W];
          REG_SR:              rd = sr;
          REG_ACR:             rd = acr;
          REG_PCR:             rd = pcr;
          REG_IFR: begin
            // value returned first, then all flags drop
            rd       = {irq_now, ifr};
            ifr_next = '0;
          end
          REG_IER:             rd = {1'b1, ier};
        endcase
      end

      FUNC_WRITE: begin
        unique case (reg_addr_t'(item.reg_offset)) inside
          REG_ORB:             orb_next = (orb & ~ddrb) | (item.write_data & ddrb);
          REG_ORA, REG_ORA_NH: ora_next = (ora & ~ddra) | (item.write_data & ddra);
          REG_DDRB:            ddrb_next = item.write_data;
          REG_DDRA:            ddra_next = item.write_data;
          REG_T1CL, REG_T1LL:  t1l_lo_next = item.write_data;
          REG_T1CH: begin
            t1c_next              = {item.write_data, t1l_lo};
            t1l_hi_next           = item.write_data;
            ifr_next[FLAG_T1_BIT] = 1'b0;
            t1_armed_next         = 1'b1;
          end
          REG_T1LH: begin
            t1l_hi_next           = item.write_data;
            ifr_next[FLAG_T1_BIT] = 1'b0;
          end
          REG_T2CL:            t2_latch_lo_next = item.write_data;
          REG_T2CH: begin
            t2c_next              = {item.write_data, t2_latch_lo};
            ifr_next[FLAG_T2_BIT] = 1'b0;
            t2_armed_next         = 1'b1;
          end
          REG_SR:              sr_next = item.write_data;
          REG_ACR:             acr_next = item.write_data;
          REG_PCR:             pcr_next = item.write_data;
          REG_IFR:             ifr_next = ifr & ~item.write_data[IRQ_W-1:0];
          REG_IER: begin
            // bit 7 selects set or clear of the given enables
            if (item.write_data[DATA_W-1]) begin
              ier_next = ier | item.write_data[IRQ_W-1:0];
            end else begin
              ier_next = ier & ~item.write_data[IRQ_W-1:0];
            end
          end
        endcase
      end

      FUNC_TICK: begin
        // Timer 1: zero, then one tick later schedule reload, reload on the next
        t1c_next = t1_dec;
        if (t1_dec == '0) begin
          t1_at_zero_next = 1'b1;
          if (t1_armed) begin
            ifr_next[FLAG_T1_BIT] = 1'b1;
            if (!acr[ACR_FREE_RUN_BIT]) begin
              t1_armed_next = 1'b0;
            end
          end
        end else if (t1_at_zero) begin
          t1_at_zero_next        = 1'b0;
          t1_reload_pending_next = 1'b1;
        end else if (t1_reload_pending) begin
          t1_reload_pending_next = 1'b0;
          t1c_next               = {t1l_hi, t1l_lo};
        end
        // Timer 2: one-shot
        t2c_next = t2_dec;
        if ((t2_dec == '0) && t2_armed) begin
          t2_armed_next         = 1'b0;
          ifr_next[FLAG_T2_BIT] = 1'b1;
        end
      end

      default: begin
        rd = '0;
      end
    endcase
  end

  assign result.read_data   = rd;
  assign result.irq_request = |(ifr_next & ier_next);

  assign status.irq               = irq_now;
  assign status.t1_at_zero        = t1_at_zero;
  assign status.t1_reload_pending = t1_reload_pending;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      orb               <= '0;
      ora               <= '0;
      ddrb              <= '0;
      ddra              <= '0;
      t1c               <= T1_RESET;
      t2c               <= '0;
      t1l_lo            <= '0;
      t1l_hi            <= '0;
      t2_latch_lo       <= '0;
      sr                <= '0;
      acr               <= '0;
      pcr               <= '0;
      ifr               <= '0;
      ier               <= '0;
      t1_armed          <= 1'b0;
      t2_armed          <= 1'b0;
      t1_at_zero        <= 1'b0;
      t1_reload_pending <= 1'b0;
    end else if (fire) begin
      orb               <= orb_next;
      ora               <= ora_next;
      ddrb              <= ddrb_next;
      ddra              <= ddra_next;
      t1c               <= t1c_next;
      t2c               <= t2c_next;
      t1l_lo            <= t1l_lo_next;
      t1l_hi            <= t1l_hi_next;
      t2_latch_lo       <= t2_latch_lo_next;
      sr                <= sr_next;
      acr               <= acr_next;
      pcr               <= pcr_next;
      ifr               <= ifr_next;
      ier               <= ier_next;
      t1_armed          <= t1_armed_next;
      t2_armed          <= t2_armed_next;
      t1_at_zero        <= t1_at_zero_next;
      t1_reload_pending <= t1_reload_pending_next;
    end
  end

endmodule

### hw/rtl/via_timer_interrupt_registers.sv
// Top level: input register, register/timer core and result register with checks.
// Each command item (bus read, bus write or one timer tick) runs through an input
// register and a single pass of register/timer logic into a result register, so the
// block takes one item every clock cycle while rsp drains results, and it returns
// each result from the result register. The only thing that slows it is the result
// register: while a result waits on rsp, one further item is held in the input
// register, and the block stops taking items after that. irq_request on each result
// is the interrupt line as it stands after that item. There is no start-up sequence;
// items are taken right after reset.
module via_timer_interrupt_registers (
  input logic        clk,
  input logic        rst,
  vtir_cmd_if.sink   cmd,
  vtir_rsp_if.source rsp
);
  import vtir_pkg::*;

  logic         stage_valid;
  logic         fire;
  vtir_item_t   item;
  vtir_result_t result;
  vtir_status_t status;

  // Execute when an item is held and the result slot is free or being drained
  assign fire = stage_valid && (!rsp.valid || rsp.ready);

  vtir_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .advance     (fire),
    .stage_valid (stage_valid),
    .item        (item)
  );

  vtir_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result),
    .status (status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.read_data   <= result.read_data;
      rsp.irq_request <= result.irq_request;
    end
  end

  // The interrupt line in the latest result tracks the live flag/enable state
  a_irq_matches_state: assert property (@(posedge clk) disable iff (rst)
    $past(fire) |-> (rsp.irq_request == status.irq))
    else $error("irq_request does not match flag and enable state");

  // Timer 1 reload is only scheduled out of the at-zero phase
  a_t1_reload_after_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(status.t1_reload_pending) |-> $past(status.t1_at_zero))
    else $error("timer 1 reload scheduled without a preceding zero");

  // Enable register always reads with bit 7 set
  a_ier_read_bit7: assert property (@(posedge clk) disable iff (rst)
    $past(fire && (item.func == FUNC_READ) && (item.reg_offset == REG_IER))
    |-> rsp.read_data[DATA_W-1])
    else $error("IER read without bit 7 set");

  // Writes and ticks return zero read data
  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    $past(fire && (item.func != FUNC_READ)) |-> (rsp.read_data == '0))
    else $error("non-read item returned nonzero read data");

endmodule

### tb/tb.sv
// Testbench for the 6522-style timer and interrupt register block.
`timescale 1ns / 1ps

import vtir_pkg::*;

// Register and timer model of the adapter, with the queue of results still owed
class via_scoreboard;
  localparam logic [DATA_W-1:0] T1_FLAG  = 8'd1 << FLAG_T1_BIT;
  localparam logic [DATA_W-1:0] T2_FLAG  = 8'd1 << FLAG_T2_BIT;
  localparam logic [DATA_W-1:0] IRQ_MASK = 8'h7F;
  localparam logic [DATA_W-1:0] IER_TOP  = 8'h80;

  logic [DATA_W-1:0] regfile [16];
  logic [DATA_W-1:0] t2_low_latch;
  logic              t1_running;
  logic              t2_running;
  logic              t1_hit_zero;
  logic              t1_reload_due;
  vtir_result_t      expected_q [$];
  int                errors;

  function new();
    errors = 0;
    reset_state();
  endfunction

  function void reset_state();
    foreach (regfile[i]) regfile[i] = '0;
    regfile[REG_IER] = IER_TOP;
    {regfile[REG_T1CH], regfile[REG_T1CL]} = T1_RESET;
    t2_low_latch  = '0;
    t1_running    = 1'b0;
    t2_running    = 1'b0;
    t1_hit_zero   = 1'b0;
    t1_reload_due = 1'b0;
  endfunction

  function logic irq_line();
    return |(regfile[REG_IFR] & regfile[REG_IER] & IRQ_MASK);
  endfunction

  function void clear_flags(logic [DATA_W-1:0] bits);
    regfile[REG_IFR] = regfile[REG_IFR] & ~bits & IRQ_MASK;
  endfunction

  // One timer tick: timer 1 reloads two ticks after zero, timer 2 is one-shot
  function void tick_timers();
    logic [CNT_W-1:0] t1;
    logic [CNT_W-1:0] t2;
    t1 = {regfile[REG_T1CH], regfile[REG_T1CL]} - 1'b1;
    if (t1 == '0) begin
      t1_hit_zero = 1'b1;
      if (t1_running) begin
        regfile[REG_IFR] = regfile[REG_IFR] | T1_FLAG;
        if (!regfile[REG_ACR][ACR_FREE_RUN_BIT]) t1_running = 1'b0;
      end
    end else if (t1_hit_zero) begin
      t1_hit_zero   = 1'b0;
      t1_reload_due = 1'b1;
    end else if (t1_reload_due) begin
      t1_reload_due = 1'b0;
      t1 = {regfile[REG_T1LH], regfile[REG_T1LL]};
    end
    {regfile[REG_T1CH], regfile[REG_T1CL]} = t1;

    t2 = {regfile[REG_T2CH], regfile[REG_T2CL]} - 1'b1;
    {regfile[REG_T2CH], regfile[REG_T2CL]} = t2;
    if (t2 == '0 && t2_running) begin
      t2_running = 1'b0;
      regfile[REG_IFR] = regfile[REG_IFR] | T2_FLAG;
    end
  endfunction

  function logic [DATA_W-1:0] bus_read(logic [ADDR_W-1:0] addr);
    logic [DATA_W-1:0] v;
    if (addr == REG_ORA_NH) addr = REG_ORA;
    case (addr)
      REG_IFR: begin
        // value includes the live irq bit, then every flag clears
        v = regfile[REG_IFR] | {irq_line(), 7'd0};
        clear_flags(IRQ_MASK);
      end
      REG_IER: v = regfile[REG_IER] | IER_TOP;
      REG_T1CL, REG_T1LL: begin
        clear_flags(T1_FLAG);
        v = regfile[addr];
      end
      REG_T2CL: begin
        clear_flags(T2_FLAG);
        v = regfile[addr];
      end
      default: v = regfile[addr];
    endcase
    return v;
  endfunction

  function void bus_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] val);
    if (addr == REG_ORA_NH) addr = REG_ORA;
    case (addr)
      REG_ORB: regfile[REG_ORB] = (regfile[REG_ORB] & ~regfile[REG_DDRB]) |
                                  (val & regfile[REG_DDRB]);
      REG_ORA: regfile[REG_ORA] = (regfile[REG_ORA] & ~regfile[REG_DDRA]) |
                                  (val & regfile[REG_DDRA]);
      REG_T1CL: regfile[REG_T1LL] = val;
      REG_T1CH: begin
        regfile[REG_T1CL] = regfile[REG_T1LL];
        regfile[REG_T1CH] = val;
        regfile[REG_T1LH] = val;
        clear_flags(T1_FLAG);
        t1_running = 1'b1;
      end
      REG_T1LH: begin
        regfile[REG_T1LH] = val;
        clear_flags(T1_FLAG);
      end
      REG_T2CL: t2_low_latch = val;
      REG_T2CH: begin
        regfile[REG_T2CL] = t2_low_latch;
        regfile[REG_T2CH] = val;
        clear_flags(T2_FLAG);
        t2_running = 1'b1;
      end
      REG_IFR: clear_flags(val);
      REG_IER: begin
        // bit 7 selects set or clear of the given enables
        if (val[7]) regfile[REG_IER] = regfile[REG_IER] | (val & IRQ_MASK) | IER_TOP;
        else regfile[REG_IER] = (regfile[REG_IER] & ~(val & IRQ_MASK)) | IER_TOP;
      end
      default: regfile[addr] = val;
    endcase
  endfunction

  // Accepted item: advance the model and queue the result it owes
  function void note_input(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] addr,
                           logic [DATA_W-1:0] data);
    vtir_result_t r;
    r.read_data = '0;
    case (f)
      FUNC_READ:  r.read_data = bus_read(addr);
      FUNC_WRITE: bus_write(addr, data);
      FUNC_TICK:  tick_timers();
      default: ;
    endcase
    r.irq_request = irq_line();
    expected_q.push_back(r);
  endfunction

  task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("ERROR at %0t: %s got 0x%02h, expected 0x%02h", $realtime, what, got, want);
    errors++;
  endtask

  // Accepted result: compare against the oldest owed result
  task check_result(logic [DATA_W-1:0] rd, logic irq);
    vtir_result_t e;
    if (expected_q.size() == 0) begin
      report("unexpected result, read_data", rd, '0);
      return;
    end
    e = expected_q.pop_front();
    if (rd !== e.read_data) report("read_data", rd, e.read_data);
    if (irq !== e.irq_request) report("irq_request", {7'd0, irq}, {7'd0, e.irq_request});
  endtask
endclass

module tb;
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_CHOKED} sink_mode_t;

  logic          clk;
  logic          rst;
  vtir_cmd_if    cmd ();
  vtir_rsp_if    rsp ();
  via_scoreboard sb;
  int            cycle_count;
  int            burst_left;
  int            items_counted;
  sink_mode_t    sink_mode;
  int            sink_left;

  via_timer_interrupt_registers dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Result side: ready follows a random mode: always, coin flip, periodic or rarely ready
  initial begin
    rsp.ready = 1'b0;
    sink_mode = SINK_OPEN;
    sink_left = 0;
    forever begin
      @(negedge clk);
      if (sink_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_left = $urandom_range(32, 256);
      end else begin
        sink_left--;
      end
      case (sink_mode)
        SINK_OPEN:     rsp.ready <= 1'b1;
        SINK_COIN:     rsp.ready <= 1'($urandom_range(0, 1));
        SINK_PERIODIC: rsp.ready <= (cycle_count % 4 != 0);
        default:       rsp.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Accepted items and results go to the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd.valid && cmd.ready) sb.note_input(cmd.func, cmd.reg_offset, cmd.write_data);
      if (rsp.valid && rsp.ready) sb.check_result(rsp.read_data, rsp.irq_request);
    end
  end

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      cmd.valid <= 1'b0;
    end
  endtask

  // Drive one item, in bursts with random gaps between them
  task automatic send_item(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] addr,
                           logic [DATA_W-1:0] data);
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) != 0) idle_for($urandom_range(1, 6));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    cmd.valid      <= 1'b1;
    cmd.func       <= f;
    cmd.reg_offset <= addr;
    cmd.write_data <= data;
    do @(posedge clk); while (!cmd.ready);
    if (f != FUNC_NOP) items_counted++;
  endtask

  // Program the timers with short counts, then tick with reads and IFR writes mixed in
  task automatic run_timer_sequence();
    int n_ticks;
    if ($urandom_range(0, 1) == 1) send_item(FUNC_WRITE, REG_ACR, 8'($urandom));
    if ($urandom_range(0, 2) == 0) send_item(FUNC_WRITE, REG_IER, 8'($urandom));
    if ($urandom_range(0, 3) != 0) begin
      send_item(FUNC_WRITE, REG_T1CL, 8'($urandom_range(0, 12)));
      send_item(FUNC_WRITE, REG_T1CH,
                ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
      if ($urandom_range(0, 2) == 0)
        send_item(FUNC_WRITE, REG_T1LL, 8'($urandom_range(0, 12)));
    end
    if ($urandom_range(0, 1) == 1) begin
      send_item(FUNC_WRITE, REG_T2CL, 8'($urandom_range(0, 15)));
      send_item(FUNC_WRITE, REG_T2CH,
                ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
    end
    n_ticks = $urandom_range(1, 30);
    repeat (n_ticks) begin
      case ($urandom_range(0, 9))
        0: send_item(FUNC_READ, REG_IFR, 8'($urandom));
        1: send_item(FUNC_READ, 4'($urandom), 8'($urandom));
        2: send_item(FUNC_WRITE, REG_IFR, 8'($urandom));
        default: send_item(FUNC_TICK, 4'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    sb             = new();
    rst            = 1'b1;
    cmd.valid      = 1'b0;
    cmd.func       = FUNC_READ;
    cmd.reg_offset = REG_ORB;
    cmd.write_data = '0;
    burst_left     = 0;
    items_counted  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset values, port masking, alias, enables, flags, both timers
    send_item(FUNC_READ, REG_IER, 8'h00);
    send_item(FUNC_READ, REG_T1CL, 8'h00);
    send_item(FUNC_WRITE, REG_DDRB, 8'hF0);
    send_item(FUNC_WRITE, REG_ORB, 8'hFF);
    send_item(FUNC_READ, REG_ORB, 8'h00);
    send_item(FUNC_WRITE, REG_DDRA, 8'h0F);
    send_item(FUNC_WRITE, REG_ORA_NH, 8'hAA);
    send_item(FUNC_READ, REG_ORA, 8'h00);
    send_item(FUNC_WRITE, REG_IER, 8'hFF);
    send_item(FUNC_WRITE, REG_IER, 8'h1F);
    send_item(FUNC_WRITE, REG_T1CL, 8'h02);
    send_item(FUNC_WRITE, REG_T1CH, 8'h00);
    send_item(FUNC_TICK, REG_ORB, 8'h00);
    send_item(FUNC_TICK, REG_IER, 8'hFF);
    send_item(FUNC_READ, REG_IFR, 8'h00);
    send_item(FUNC_WRITE, REG_T2CL, 8'h01);
    send_item(FUNC_WRITE, REG_T2CH, 8'h00);
    send_item(FUNC_TICK, REG_ORB, 8'h00);
    send_item(FUNC_READ, REG_T2CL, 8'h00);
    send_item(FUNC_WRITE, REG_IFR, 8'hFF);
    send_item(FUNC_WRITE, REG_T1LH, 8'h00);
    send_item(FUNC_READ, REG_T1LL, 8'h00);
    send_item(FUNC_WRITE, REG_ACR, 8'h40);
    send_item(FUNC_NOP, REG_ORA_NH, 8'hFF);
    send_item(FUNC_WRITE, REG_SR, 8'h00);

    // Random: mostly timer sequences, the rest any item at all
    items_counted = 0;
    while (items_counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        run_timer_sequence();
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom_range(0, 3)), 4'($urandom), 8'($urandom));
      end
    end

    @(negedge clk);
    cmd.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### filelist.f
hw/rtl/vtir_pkg.sv
hw/rtl/vtir_if.sv
hw/rtl/vtir_in_stage.sv
hw/rtl/vtir_regs.sv
hw/rtl/via_timer_interrupt_registers.sv
tb/tb.sv
